[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FJ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition at one edge implies the expression at the next edge
`define FJ_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[src/fjdat_pkg.sv]
// package with the codes, characters and result type of the json tokenizer
`default_nettype none

package fjdat_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	// parser phases
	localparam logic [2:0] PH_START    = 3'd0;
	localparam logic [2:0] PH_DICT     = 3'd1;
	localparam logic [2:0] PH_KEY      = 3'd2;
	localparam logic [2:0] PH_IN_KEY   = 3'd3;
	localparam logic [2:0] PH_VALUE    = 3'd4;
	localparam logic [2:0] PH_IN_VALUE = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;
	localparam logic [2:0] PH_ERROR    = 3'd7;

	// event codes
	localparam logic [2:0] EV_OPEN   = 3'd0;
	localparam logic [2:0] EV_KCHAR  = 3'd1;
	localparam logic [2:0] EV_KEND   = 3'd2;
	localparam logic [2:0] EV_VCHAR  = 3'd3;
	localparam logic [2:0] EV_VEND   = 3'd4;
	localparam logic [2:0] EV_CLOSE  = 3'd5;
	localparam logic [2:0] EV_ACLOSE = 3'd6;
	localparam logic [2:0] EV_ERROR  = 3'd7;

	// characters
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  ch;
		logic [15:0] obj;
		logic [15:0] pair;
		logic [31:0] off;
		logic        last;
	} fjdat_res_t;

	function automatic fjdat_res_t fjdat_mk(logic [2:0] ev, logic [7:0] ch,
			logic [15:0] obj, logic [15:0] pair, logic [31:0] off);
		fjdat_res_t r;
		r.ev   = ev;
		r.ch   = ch;
		r.obj  = obj;
		r.pair = pair;
		r.off  = off;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

[src/flat_json_dict_array_tokenizer.sv]
// top level of the flat json object-array tokenizer
// usage:
//   the slave stream carries the text one byte per request: s_tdata is the
//   byte, s_tlast marks the final byte of a text. the master stream carries
//   events: m_tuser is the event code, m_tdata holds the character, object
//   count, pair count and byte offset, m_tlast marks the final event that a
//   byte caused (bytes such as whitespace cause none).
//   the events of a byte are registered in the event queue before they are valid.
//   throughput: one byte per cycle while each byte gives at most one event
//   and the receiver keeps up; the master side sends events one at a time,
//   and a four-entry event queue absorbs a byte's two events, so s_tready only
//   drops while three or more events wait (the queue needs room for two).
//   a stalled receiver fills the queue, then s_tready goes low; no event is
//   lost or repeated.
//   reset clears the parser to "before the opening bracket" with all counts
//   at zero and empties the queue. the final byte of a text also returns the
//   parser to that state after its events are queued.
`default_nettype none

`include "assert_macros.svh"

module flat_json_dict_array_tokenizer
	import fjdat_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [7:0] char_out, [23:8] object_index,
	                                    // [39:24] pair_index, [71:40] byte_offset
	output logic [2:0]       m_tuser,   // [2:0] event_res
	output logic             m_tlast    // last_of_run
);

	// parser state
	logic [2:0]             phase_q, phase_d;
	logic                   quo_q, quo_d;
	logic                   esc_q, esc_d;
	logic                   sep_q, sep_d;
	logic [31:0]            pos_q, pos_d;
	logic [COUNT_WIDTH-1:0] objs_q, objs_d;
	logic [COUNT_WIDTH-1:0] pairs_q, pairs_d;

	// events of the current byte
	fjdat_res_t             res_d [2];
	logic [1:0]             nres_d;

	// event queue
	fjdat_res_t             fifo_q [4];
	logic [1:0]             wr_ptr_q, rd_ptr_q;
	logic [2:0]             cnt_q;

	logic [7:0]             b;
	logic                   is_ws, is_term, accept, pop;
	logic [2:0]             chev;
	logic [1:0]             push_n;

	assign b       = s_tdata;
	assign is_ws   = b inside {CH_SPACE, [CH_TAB:CH_CR]};
	assign is_term = b inside {CH_SPACE, CH_COMMA, CH_RBRACE, CH_RBRACKET};
	assign chev    = (phase_q == PH_IN_KEY) ? EV_KCHAR : EV_VCHAR;

	assign s_tready = (cnt_q <= 3'd2);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != 3'd0);
	assign pop      = m_tvalid && m_tready;
	assign push_n   = accept ? nres_d : 2'd0;

	// one byte through the parser; each event snapshots the counts as they
	// stand at the moment it is raised
	always_comb begin
		phase_d  = phase_q;
		quo_d    = quo_q;
		esc_d    = esc_q;
		sep_d    = sep_q;
		objs_d   = objs_q;
		pairs_d  = pairs_q;
		res_d[0] = fjdat_mk(EV_OPEN, 8'd0, 16'd0, 16'd0, 32'd0);
		res_d[1] = fjdat_mk(EV_OPEN, 8'd0, 16'd0, 16'd0, 32'd0);
		nres_d   = 2'd0;

		if (phase_q == PH_IN_KEY || phase_q == PH_IN_VALUE) begin
			if (!quo_q) begin
				if (!is_term) begin
					res_d[nres_d[0]] = fjdat_mk(chev, b, 16'(objs_d), 16'(pairs_d), pos_q);
					nres_d = nres_d + 2'd1;
				end else begin
					// unquoted string ends; the terminator is then parsed again
					esc_d = 1'b0;
					quo_d = 1'b0;
					sep_d = 1'b0;
					if (phase_q == PH_IN_KEY) begin
						res_d[nres_d[0]] = fjdat_mk(EV_KEND, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_VALUE;
					end else begin
						if (pairs_d != '1) pairs_d = pairs_d + COUNT_WIDTH'(1);
						res_d[nres_d[0]] = fjdat_mk(EV_VEND, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_KEY;
					end
					if (b != CH_SPACE) begin
						if (phase_d == PH_VALUE || b == CH_RBRACKET) begin
							res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d),
								16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
							phase_d = PH_ERROR;
						end else if (b == CH_COMMA) begin
							sep_d = 1'b1;
						end else begin
							// closing brace after a value
							if (pairs_d != '0) begin
								if (objs_d != '1) objs_d = objs_d + COUNT_WIDTH'(1);
								res_d[nres_d[0]] = fjdat_mk(EV_CLOSE, 8'd0, 16'(objs_d),
									16'(pairs_d), pos_q);
								nres_d = nres_d + 2'd1;
							end
							phase_d = PH_DICT;
							sep_d   = 1'b0;
						end
					end
				end
			end else begin
				// quoted string: only a backslash before a quote is an escape
				if (esc_q) begin
					esc_d = 1'b0;
					res_d[nres_d[0]] = fjdat_mk(chev, (b == CH_QUOTE) ? CH_QUOTE : CH_BSLASH,
						16'(objs_d), 16'(pairs_d), pos_q);
					nres_d = nres_d + 2'd1;
				end
				if (!(esc_q && b == CH_QUOTE)) begin
					if (b == CH_BSLASH) begin
						esc_d = 1'b1;
					end else if (b == CH_QUOTE) begin
						esc_d = 1'b0;
						quo_d = 1'b0;
						sep_d = 1'b0;
						if (phase_q == PH_IN_KEY) begin
							res_d[nres_d[0]] = fjdat_mk(EV_KEND, 8'd0, 16'(objs_d),
								16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
							phase_d = PH_VALUE;
						end else begin
							if (pairs_d != '1) pairs_d = pairs_d + COUNT_WIDTH'(1);
							res_d[nres_d[0]] = fjdat_mk(EV_VEND, 8'd0, 16'(objs_d),
								16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
							phase_d = PH_KEY;
						end
					end else begin
						res_d[nres_d[0]] = fjdat_mk(chev, b, 16'(objs_d), 16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
					end
				end
			end
		end else if (phase_q != PH_DONE && phase_q != PH_ERROR && !is_ws) begin
			case (phase_q)
				PH_START: begin
					if (b == CH_LBRACKET) begin
						phase_d = PH_DICT;
						sep_d   = 1'b0;
					end else begin
						res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_ERROR;
					end
				end
				PH_DICT: begin
					if (b == CH_LBRACE) begin
						pairs_d = '0;
						sep_d   = 1'b0;
						phase_d = PH_KEY;
					end else if (!sep_q && b == CH_COMMA) begin
						sep_d = 1'b1;
					end else if (!sep_q && b == CH_RBRACKET) begin
						res_d[nres_d[0]] = fjdat_mk(EV_ACLOSE, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_DONE;
					end else begin
						// a comma between objects must be followed by a brace
						res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_ERROR;
					end
				end
				PH_KEY, PH_VALUE: begin
					if (!sep_q && phase_q == PH_KEY && b == CH_RBRACE) begin
						// empty objects give neither open nor close
						if (pairs_d != '0) begin
							if (objs_d != '1) objs_d = objs_d + COUNT_WIDTH'(1);
							res_d[nres_d[0]] = fjdat_mk(EV_CLOSE, 8'd0, 16'(objs_d),
								16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
						end
						phase_d = PH_DICT;
						sep_d   = 1'b0;
					end else if (!sep_q && phase_q == PH_KEY && b == CH_COMMA) begin
						sep_d = 1'b1;
					end else if (!sep_q && phase_q == PH_VALUE && b == CH_COLON) begin
						sep_d = 1'b1;
					end else if (b != CH_QUOTE && is_term) begin
						// empty unquoted string
						res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d),
							16'(pairs_d), pos_q);
						nres_d = nres_d + 2'd1;
						phase_d = PH_ERROR;
					end else begin
						if (phase_q == PH_KEY && pairs_d == '0) begin
							res_d[nres_d[0]] = fjdat_mk(EV_OPEN, 8'd0, 16'(objs_d),
								16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
						end
						esc_d   = 1'b0;
						phase_d = (phase_q == PH_KEY) ? PH_IN_KEY : PH_IN_VALUE;
						quo_d   = (b == CH_QUOTE);
						if (b != CH_QUOTE) begin
							res_d[nres_d[0]] = fjdat_mk((phase_q == PH_KEY) ? EV_KCHAR : EV_VCHAR,
								b, 16'(objs_d), 16'(pairs_d), pos_q);
							nres_d = nres_d + 2'd1;
						end
					end
				end
				default: begin
					res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d),
						16'(pairs_d), pos_q);
					nres_d = nres_d + 2'd1;
					phase_d = PH_ERROR;
				end
			endcase
		end

		// text ends before the array closed: error replaces any second event
		if (s_tlast && phase_d != PH_DONE && phase_d != PH_ERROR) begin
			if (nres_d == 2'd2) nres_d = 2'd1;
			res_d[nres_d[0]] = fjdat_mk(EV_ERROR, 8'd0, 16'(objs_d), 16'(pairs_d), pos_q);
			nres_d = nres_d + 2'd1;
		end

		if (nres_d == 2'd1) res_d[0].last = 1'b1;
		if (nres_d == 2'd2) res_d[1].last = 1'b1;

		// position count and return to reset state at end of text
		if (s_tlast) begin
			phase_d = PH_START;
			quo_d   = 1'b0;
			esc_d   = 1'b0;
			sep_d   = 1'b0;
			objs_d  = '0;
			pairs_d = '0;
			pos_d   = '0;
		end else begin
			pos_d   = (pos_q == '1) ? pos_q : pos_q + 32'd1;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			quo_q   <= 1'b0;
			esc_q   <= 1'b0;
			sep_q   <= 1'b0;
			pos_q   <= '0;
			objs_q  <= '0;
			pairs_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			quo_q   <= quo_d;
			esc_q   <= esc_d;
			sep_q   <= sep_d;
			pos_q   <= pos_d;
			objs_q  <= objs_d;
			pairs_q <= pairs_d;
		end
	end

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	// queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res_d[0];
		if (push_n == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= res_d[1];
	end

	assign m_tuser = fifo_q[rd_ptr_q].ev;
	assign m_tdata = {fifo_q[rd_ptr_q].off, fifo_q[rd_ptr_q].pair,
		fifo_q[rd_ptr_q].obj, fifo_q[rd_ptr_q].ch};
	assign m_tlast = fifo_q[rd_ptr_q].last;

	// checks
	`FJ_ASSERT(a_cnt_range, cnt_q <= 3'd4, "event queue overfilled")
	`FJ_ASSERT(a_cnt_ptrs, cnt_q[1:0] == 2'(wr_ptr_q - rd_ptr_q), "queue count off pointers")
	`FJ_ASSERT(a_esc_quoted, !esc_q || quo_q, "escape flag outside a quoted string")
	`FJ_ASSERT_NEXT(a_eot_reset, accept && s_tlast,
		phase_q == PH_START && pos_q == 32'd0 && pairs_q == '0,
		"parser not reset after end of text")

endmodule

`default_nettype wire

[test/json_event_checker.sv]
// checker: predicts the tokenizer events for each text byte and compares them with the stream
`timescale 1ns / 100ps

module json_event_checker
	import fjdat_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // end_of_text
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,   // [7:0] char_out, [23:8] object_index,
	                                    // [39:24] pair_index, [71:40] byte_offset
	input  wire logic [2:0]  m_tuser,   // [2:0] event_res
	input  wire logic        m_tlast,   // last_of_run
	output int               failures,
	output int               events_waiting,
	output int               bytes_taken,
	output int               texts_taken,
	output int               events_taken,
	output int               error_events
);

	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH_DEF) - 64'd1);

	// predicted parser state
	logic [2:0]  tk_phase;
	logic        tk_quoted;
	logic        tk_escaped;
	logic        tk_sep;
	logic [31:0] tk_pos;
	logic [31:0] tk_objs;
	logic [31:0] tk_pairs;

	// events of the byte being predicted, then the store of pending events
	fjdat_res_t  byte_events[4];
	int          n_byte_events;
	fjdat_res_t  expected_events[$];

	int          fail_count;
	int          n_bytes;
	int          n_texts;
	int          n_events;
	int          n_errors;

	function automatic logic ends_bare(input logic [7:0] b);
		return b == CH_SPACE || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACKET;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	task automatic clear_tokenizer();
		tk_phase   = PH_START;
		tk_quoted  = 1'b0;
		tk_escaped = 1'b0;
		tk_sep     = 1'b0;
		tk_pos     = '0;
		tk_objs    = '0;
		tk_pairs   = '0;
	endtask

	task automatic note_event(input logic [2:0] ev, input logic [7:0] ch);
		if (n_byte_events < 4) begin
			byte_events[n_byte_events].ev   = ev;
			byte_events[n_byte_events].ch   = ch;
			byte_events[n_byte_events].obj  = tk_objs[15:0];
			byte_events[n_byte_events].pair = tk_pairs[15:0];
			byte_events[n_byte_events].off  = tk_pos;
			byte_events[n_byte_events].last = 1'b0;
			n_byte_events++;
		end
	endtask

	task automatic raise_error();
		note_event(EV_ERROR, 8'h00);
		tk_phase = PH_ERROR;
	endtask

	// empty objects give no close event
	task automatic finish_object();
		if (tk_pairs != 0) begin
			if (tk_objs < COUNT_MAX)
				tk_objs++;
			note_event(EV_CLOSE, 8'h00);
		end
		tk_phase = PH_DICT;
		tk_sep   = 1'b0;
	endtask

	task automatic open_string(input logic [7:0] b, input logic is_key);
		if (b != CH_QUOTE && ends_bare(b)) begin
			raise_error();
			return;
		end
		if (is_key && tk_pairs == 0)
			note_event(EV_OPEN, 8'h00);
		tk_escaped = 1'b0;
		tk_phase   = is_key ? PH_IN_KEY : PH_IN_VALUE;
		tk_quoted  = (b == CH_QUOTE);
		if (b != CH_QUOTE)
			note_event(is_key ? EV_KCHAR : EV_VCHAR, b);
	endtask

	task automatic close_string();
		tk_escaped = 1'b0;
		tk_quoted  = 1'b0;
		tk_sep     = 1'b0;
		if (tk_phase == PH_IN_KEY) begin
			note_event(EV_KEND, 8'h00);
			tk_phase = PH_VALUE;
		end else begin
			if (tk_pairs < COUNT_MAX)
				tk_pairs++;
			note_event(EV_VEND, 8'h00);
			tk_phase = PH_KEY;
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] b);
		logic [2:0] char_ev;
		char_ev = (tk_phase == PH_IN_KEY) ? EV_KCHAR : EV_VCHAR;
		if (tk_phase == PH_IN_KEY || tk_phase == PH_IN_VALUE) begin
			if (!tk_quoted) begin
				if (!ends_bare(b)) begin
					note_event(char_ev, b);
				end else begin
					// the terminator is handled again in the new phase
					close_string();
					if (b != CH_SPACE) begin
						if (tk_phase == PH_VALUE)
							raise_error();
						else if (b == CH_COMMA)
							tk_sep = 1'b1;
						else if (b == CH_RBRACE)
							finish_object();
						else
							raise_error();
					end
				end
			end else begin
				if (tk_escaped) begin
					tk_escaped = 1'b0;
					if (b == CH_QUOTE) begin
						note_event(char_ev, CH_QUOTE);
						return;
					end
					// backslash before anything else stands for itself
					note_event(char_ev, CH_BSLASH);
				end
				if (b == CH_BSLASH)
					tk_escaped = 1'b1;
				else if (b == CH_QUOTE)
					close_string();
				else
					note_event(char_ev, b);
			end
		end else if (tk_phase != PH_DONE && tk_phase != PH_ERROR && !is_blank(b)) begin
			case (tk_phase)
				PH_START: begin
					if (b == CH_LBRACKET) begin
						tk_phase = PH_DICT;
						tk_sep   = 1'b0;
					end else begin
						raise_error();
					end
				end
				PH_DICT: begin
					if (b == CH_LBRACE) begin
						tk_pairs = '0;
						tk_sep   = 1'b0;
						tk_phase = PH_KEY;
					end else if (tk_sep) begin
						raise_error();
					end else if (b == CH_COMMA) begin
						tk_sep = 1'b1;
					end else if (b == CH_RBRACKET) begin
						note_event(EV_ACLOSE, 8'h00);
						tk_phase = PH_DONE;
					end else begin
						raise_error();
					end
				end
				PH_KEY: begin
					if (!tk_sep && b == CH_RBRACE)
						finish_object();
					else if (!tk_sep && b == CH_COMMA)
						tk_sep = 1'b1;
					else
						open_string(b, 1'b1);
				end
				default: begin
					if (tk_phase != PH_VALUE)
						raise_error();
					else if (!tk_sep && b == CH_COLON)
						tk_sep = 1'b1;
					else
						open_string(b, 1'b0);
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		fjdat_res_t got;
		fjdat_res_t want;
		if (!arst_n) begin
			clear_tokenizer();
			expected_events.delete();
		end else begin
			// compare first: an event leaving now comes from an earlier byte
			if (m_tvalid && m_tready) begin
				n_events++;
				got.ev   = m_tuser;
				got.ch   = m_tdata[7:0];
				got.obj  = m_tdata[23:8];
				got.pair = m_tdata[39:24];
				got.off  = m_tdata[71:40];
				got.last = m_tlast;
				if (got.ev == EV_ERROR)
					n_errors++;
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: event with nothing expected: ev=%0d ch=%h obj=%0d pair=%0d",
						$time, got.ev, got.ch, got.obj, got.pair);
					$display("%0t: off=%0d last=%0b", $time, got.off, got.last);
				end else begin
					want = expected_events.pop_front();
					if (got.ev !== want.ev || got.ch !== want.ch || got.obj !== want.obj ||
							got.pair !== want.pair || got.off !== want.off ||
							got.last !== want.last) begin
						fail_count++;
						$display("%0t: expected ev=%0d ch=%h obj=%0d pair=%0d off=%0d last=%0b",
							$time, want.ev, want.ch, want.obj, want.pair, want.off, want.last);
						$display("%0t: got      ev=%0d ch=%h obj=%0d pair=%0d off=%0d last=%0b",
							$time, got.ev, got.ch, got.obj, got.pair, got.off, got.last);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				n_bytes++;
				n_byte_events = 0;
				tokenize_byte(s_tdata);
				if (n_byte_events > 2)
					n_byte_events = 2;
				// unfinished text: keep the first event and end with an error
				if (s_tlast && tk_phase != PH_DONE && tk_phase != PH_ERROR) begin
					if (n_byte_events > 1)
						n_byte_events = 1;
					raise_error();
				end
				if (n_byte_events > 0)
					byte_events[n_byte_events - 1].last = 1'b1;
				for (int k = 0; k < n_byte_events; k++)
					expected_events.push_back(byte_events[k]);
				if (s_tlast) begin
					n_texts++;
					clear_tokenizer();
				end else if (tk_pos != 32'hFFFF_FFFF) begin
					tk_pos++;
				end
			end
		end
		failures       <= fail_count;
		events_waiting <= expected_events.size();
		bytes_taken    <= n_bytes;
		texts_taken    <= n_texts;
		events_taken   <= n_events;
		error_events   <= n_errors;
	end

endmodule

[test/tb_flat_json_dict_array_tokenizer.sv]
// testbench top: feeds json texts to the tokenizer, paces both streams and reports the verdict
`timescale 1ns / 100ps

module tb_flat_json_dict_array_tokenizer;
	import fjdat_pkg::*;

	localparam int RANDOM_BYTES   = 400;  // stop adding random texts past this
	localparam int IDLE_PCT       = 27;   // chance of a gap per cycle on each side
	localparam int HOLD_CYCLES    = 64;   // long receiver hold-off to fill the event queue
	localparam int WATCHDOG_LIMIT = 2000; // cycles with no request on either side
	localparam int STEADY_FROM    = 150;  // random byte span with no gaps on either side
	localparam int STEADY_TO      = 260;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
	logic        s_tlast = 1'b0;    // end_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [7:0] char_out, [23:8] object_index,
	                                // [39:24] pair_index, [71:40] byte_offset
	logic [2:0]  m_tuser;           // [2:0] event_res
	logic        m_tlast;           // last_of_run

	// pacing controls: steady turns off gaps, hold_req asks the receiver for one hold-off
	logic        steady = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;

	int          failures;
	int          events_waiting;
	int          bytes_taken;
	int          texts_taken;
	int          events_taken;
	int          error_events;

	// bytes of the text being built before it goes out
	logic [7:0]  text_bytes[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	flat_json_dict_array_tokenizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	json_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.failures       (failures),
		.events_waiting (events_waiting),
		.bytes_taken    (bytes_taken),
		.texts_taken    (texts_taken),
		.events_taken   (events_taken),
		.error_events   (error_events)
	);

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// bytes that end an unquoted string
	function automatic logic bare_end(input logic [7:0] b);
		return b == CH_SPACE || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACKET;
	endfunction

	task automatic queue_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	// optional whitespace: space or one of tab, lf, vt, ff, cr
	task automatic add_blank();
		logic [7:0] c;
		c = $urandom_range(1) ? CH_SPACE : 8'($urandom_range(13, 9));
		if ($urandom_range(3) == 0)
			text_bytes.push_back(c);
	endtask

	// quoted string with escaped quotes and lone backslashes mixed in
	task automatic add_quoted();
		logic [7:0] c;
		text_bytes.push_back(CH_QUOTE);
		repeat ($urandom_range(3)) begin
			do
				c = rand_byte();
			while (c == CH_QUOTE || c == CH_BSLASH);
			case ($urandom_range(5))
				0: begin
					text_bytes.push_back(CH_BSLASH);
					text_bytes.push_back(CH_QUOTE);
				end
				1: begin
					text_bytes.push_back(CH_BSLASH);
					text_bytes.push_back(c);
				end
				default: text_bytes.push_back(c);
			endcase
		end
		text_bytes.push_back(CH_QUOTE);
	endtask

	// unquoted string body; the caller adds the terminator
	task automatic add_bare();
		logic [7:0] c;
		do
			c = rand_byte();
		while (c == CH_QUOTE || c == CH_COLON || bare_end(c) || (c >= CH_TAB && c <= CH_CR));
		text_bytes.push_back(c);
		repeat ($urandom_range(2)) begin
			do
				c = rand_byte();
			while (bare_end(c));
			text_bytes.push_back(c);
		end
	endtask

	// one random text: mostly well-formed arrays, some cut short, some with a
	// corrupted byte, some plain noise
	task automatic build_text();
		int         kind;
		int         n_obj;
		int         n_pair;
		int         keep;
		logic       closed;
		kind = $urandom_range(9);
		if (kind == 0) begin
			repeat (1 + $urandom_range(7))
				text_bytes.push_back(rand_byte());
			return;
		end
		text_bytes.push_back(CH_LBRACKET);
		n_obj = $urandom_range(3);
		for (int o = 0; o < n_obj; o++) begin
			add_blank();
			text_bytes.push_back(CH_LBRACE);
			n_pair = $urandom_range(3);
			closed = 1'b0;
			for (int p = 0; p < n_pair; p++) begin
				add_blank();
				// key: quoted, or unquoted and ended by a space
				if ($urandom_range(1)) begin
					add_quoted();
				end else begin
					add_bare();
					text_bytes.push_back(CH_SPACE);
				end
				add_blank();
				if ($urandom_range(1))
					text_bytes.push_back(CH_COLON);
				add_blank();
				// value: an unquoted one may be ended by the pair comma or the brace
				if ($urandom_range(1)) begin
					add_quoted();
					if (p < n_pair - 1 && $urandom_range(1)) begin
						add_blank();
						text_bytes.push_back(CH_COMMA);
					end
				end else begin
					add_bare();
					case ($urandom_range(2))
						0: text_bytes.push_back(CH_SPACE);
						1: text_bytes.push_back(p < n_pair - 1 ? CH_COMMA : CH_SPACE);
						default: begin
							if (p == n_pair - 1) begin
								text_bytes.push_back(CH_RBRACE);
								closed = 1'b1;
							end else begin
								text_bytes.push_back(CH_SPACE);
							end
						end
					endcase
				end
			end
			if (!closed) begin
				add_blank();
				text_bytes.push_back(CH_RBRACE);
			end
			// a comma between objects only where another object follows
			if (o < n_obj - 1 && $urandom_range(1)) begin
				add_blank();
				text_bytes.push_back(CH_COMMA);
			end
		end
		add_blank();
		text_bytes.push_back(CH_RBRACKET);
		// junk after the closing bracket is ignored
		if ($urandom_range(3) == 0)
			text_bytes.push_back(rand_byte());
		if (kind == 1) begin
			keep = 1 + $urandom_range(text_bytes.size() - 1);
			while (text_bytes.size() > keep)
				void'(text_bytes.pop_back());
		end else if (kind == 2) begin
			text_bytes[$urandom_range(text_bytes.size() - 1)] = rand_byte();
		end
	endtask

	// one request per byte, random gaps before each unless steady
	task automatic send_byte(input logic [7:0] b, input logic is_final);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_final;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// sends the built text with end_of_text on its last byte
	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin : receiver
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_done <= 1'b1;
			end
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ends the run when no request moves on either side for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("[flat_json_dict_array_tokenizer] ERROR");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int n_text;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open with first key char, quoted value with escaped quote and a lone
		// backslash before 0xff, 0x00 in a key, unquoted value ended by the
		// brace (value end plus close), array close, then a byte after close
		queue_str("[{a \"\\\"\\");
		text_bytes.push_back(8'hFF);
		queue_str("\"k");
		text_bytes.push_back(8'h00);
		queue_str(" v}]!");
		send_text();
		// comma between objects not followed by a brace
		queue_str("[,x");
		send_text();
		// value that starts with a comma, then a byte after the error
		queue_str("[{k ,z");
		send_text();
		// text ends on a byte that gives two events: only the first stays
		queue_str("[{k v}");
		send_text();

		sent = 0;
		n_text = 0;
		while (sent < RANDOM_BYTES) begin
			if (n_text == 2)
				hold_req <= 1'b1;
			steady <= (sent >= STEADY_FROM && sent < STEADY_TO);
			build_text();
			sent += text_bytes.size();
			send_text();
			n_text++;
		end
		s_tvalid <= 1'b0;
		steady   <= 1'b1;

		// drain what is still queued, then give stray events time to show
		repeat (2)
			@(posedge clk);
		while (events_waiting != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);

		$display("run: %0d text bytes in %0d texts, %0d events compared", bytes_taken,
			texts_taken, events_taken);
		$display("run: %0d error events seen, one %0d-cycle hold-off on the event side",
			error_events, HOLD_CYCLES);
		if (failures == 0 && events_waiting == 0)
			$display("[flat_json_dict_array_tokenizer] OK");
		else
			$display("[flat_json_dict_array_tokenizer] ERROR");
		$finish;
	end

endmodule
